### hw/rtl/stepper_half_step_move_controller_unit_assert.svh
// Assertion macros used by the stepper half-step move controller RTL.
`ifndef STEPPER_HALF_STEP_MOVE_CONTROLLER_UNIT_ASSERT_SVH
`define STEPPER_HALF_STEP_MOVE_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge outside reset.
`define SHSMC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked on every clock edge outside reset.
`define SHSMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SHSMC_ASSERT_IMPL(lbl, ante, cons, msg)
`define SHSMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### hw/rtl/shsmc_pkg.sv
// Package with widths, commands and the half-step table of the move controller.
package shsmc_pkg;

    localparam int ANGLE_W = 16;
    localparam int STEPS_W = 20;
    localparam int TICKS_W = 16;
    localparam int CMD_W   = 2;

    // Reset value of the step period register.
    localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd2;

    // floor(angle * 512 / 45) == (angle * ANGLE_MULT) >> ANGLE_SHIFT for every
    // 16-bit angle; ANGLE_MULT is ceil(2^37 / 45) and the shift absorbs the 512.
    localparam logic [31:0] ANGLE_MULT  = 32'd3054198967;
    localparam int          ANGLE_SHIFT = 28;
    localparam int          PROD_W      = ANGLE_W + 32;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } cmd_t;

    // Half-step coil pattern, phase A in bit 0 through phase D in bit 3.
    function automatic logic [3:0] half_step_pattern(input logic [2:0] idx);
        logic [3:0] pat;
        unique case (idx)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

endpackage

### hw/rtl/stepper_half_step_move_controller_unit.sv
// Top level of the stepper half-step move controller.
//
//  Channel  Signals                         Direction  Beat contents
//  in       in_valid / in_stall             input      command, angle, direction
//  out      out_valid / out_stall           output     phase_a..d, moving, steps_left
//  cfg      cfg_valid / cfg_ready           input      ticks_per_step
//
// Each beat passes from the input stage, where the step count of the angle-to-step
// multiply is registered, to the second stage, which updates the move state and
// loads the result register. One beat is accepted per clock while the result
// side keeps up; the state update in the second stage is the only feedback
// loop. A stalled result holds the second stage, and the input stage still
// takes one more beat. Reset clears the move state and sets the step period
// to two ticks; the configuration port is always ready.
`include "stepper_half_step_move_controller_unit_assert.svh"

module stepper_half_step_move_controller_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Input beat channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [shsmc_pkg::CMD_W-1:0]    command,
    input  logic [shsmc_pkg::ANGLE_W-1:0]  angle,
    input  logic                           direction,
    // Result beat channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           phase_a,
    output logic                           phase_b,
    output logic                           phase_c,
    output logic                           phase_d,
    output logic                           moving,
    output logic [shsmc_pkg::STEPS_W-1:0]  steps_left,
    // Configuration channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [shsmc_pkg::TICKS_W-1:0]  ticks_per_step
);
    import shsmc_pkg::*;

    // Configuration register
    logic [TICKS_W-1:0] tps_reg;

    // Input stage
    logic               s1_valid_reg;
    logic [CMD_W-1:0]   s1_cmd_reg;
    logic [STEPS_W-1:0] s1_pulses_reg;
    logic               s1_dir_reg;
    logic               s1_advance;
    logic [PROD_W-1:0]  angle_prod;
    logic [STEPS_W-1:0] pulses_in;

    // Move state
    logic [2:0]         idx_reg,   idx_next;
    logic [STEPS_W-1:0] rem_reg,   rem_next;
    logic [TICKS_W-1:0] dc_reg,    dc_next;
    logic               busy_reg,  busy_next;
    logic               mdir_reg,  mdir_next;
    logic [3:0]         phase_reg, phase_next;

    // Step helpers
    logic [TICKS_W-1:0] period;
    logic [TICKS_W-1:0] dc_dec;
    logic               step_dir;
    logic [2:0]         idx_back;
    logic [2:0]         idx_fwd;
    logic [2:0]         idx_drive;
    logic [2:0]         idx_after;

    // Result register
    logic               out_valid_reg;
    logic [3:0]         out_phase_reg;
    logic               out_moving_reg;
    logic [STEPS_W-1:0] out_steps_reg;

    assign cfg_ready = 1'b1;

    // Step period register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TICKS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tps_reg <= ticks_per_step;
        end
    end

    // Angle to half-step count by reciprocal multiplication.
    assign angle_prod = PROD_W'(angle) * PROD_W'(ANGLE_MULT);
    assign pulses_in  = angle_prod[ANGLE_SHIFT +: STEPS_W];

    // The input stage moves on when the result register is free or being taken.
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_cmd_reg    <= command;
            s1_pulses_reg <= pulses_in;
            s1_dir_reg    <= direction;
        end
    end

    // Index arithmetic for one half step in the active direction.
    assign period    = (tps_reg == '0) ? TICKS_W'(1) : tps_reg;
    assign dc_dec    = (dc_reg != '0) ? dc_reg - TICKS_W'(1) : dc_reg;
    assign step_dir  = (s1_cmd_reg == CMD_START) ? s1_dir_reg : mdir_reg;
    assign idx_back  = idx_reg - 3'd1;
    assign idx_fwd   = idx_reg + 3'd1;
    assign idx_drive = step_dir ? idx_back : idx_reg;
    assign idx_after = step_dir ? idx_back : idx_fwd;

    // Next move state for the beat in the input stage.
    always_comb
    begin
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        dc_next    = dc_reg;
        busy_next  = busy_reg;
        mdir_next  = mdir_reg;
        phase_next = phase_reg;
        unique case (s1_cmd_reg)
            CMD_TICK:
            begin
                if (busy_reg)
                begin
                    dc_next = dc_dec;
                    if (dc_dec == '0)
                    begin
                        if (rem_reg != '0)
                        begin
                            idx_next   = idx_after;
                            phase_next = half_step_pattern(idx_drive);
                            rem_next   = rem_reg - STEPS_W'(1);
                            dc_next    = period;
                        end
                        else
                        begin
                            busy_next = 1'b0;
                        end
                    end
                end
            end
            CMD_START:
            begin
                if (!busy_reg && (s1_pulses_reg != '0))
                begin
                    mdir_next  = s1_dir_reg;
                    idx_next   = idx_after;
                    phase_next = half_step_pattern(idx_drive);
                    rem_next   = s1_pulses_reg - STEPS_W'(1);
                    dc_next    = period;
                    busy_next  = 1'b1;
                end
            end
            CMD_STOP:
            begin
                busy_next  = 1'b0;
                rem_next   = '0;
                dc_next    = '0;
                phase_next = 4'b0000;
            end
            default:
            begin
                // The unused code only reports the current state.
            end
        endcase
    end

    // Move state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            rem_reg   <= '0;
            dc_reg    <= '0;
            busy_reg  <= 1'b0;
            mdir_reg  <= 1'b0;
            phase_reg <= 4'b0000;
        end
        else if (s1_advance)
        begin
            idx_reg   <= idx_next;
            rem_reg   <= rem_next;
            dc_reg    <= dc_next;
            busy_reg  <= busy_next;
            mdir_reg  <= mdir_next;
            phase_reg <= phase_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            out_phase_reg  <= phase_next;
            out_moving_reg <= busy_next;
            out_steps_reg  <= rem_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign phase_a    = out_phase_reg[0];
    assign phase_b    = out_phase_reg[1];
    assign phase_c    = out_phase_reg[2];
    assign phase_d    = out_phase_reg[3];
    assign moving     = out_moving_reg;
    assign steps_left = out_steps_reg;

    // An idle controller has no steps left to drive.
    `SHSMC_ASSERT_IMPL(a_idle_no_steps, !busy_reg, rem_reg == '0, "steps left while idle")
    // The step delay counter runs exactly while a move is in progress.
    `SHSMC_ASSERT_IMPL(a_busy_delay, 1'b1, busy_reg == (dc_reg != '0), "delay and busy disagree")
    // A move in progress always drives some coil.
    `SHSMC_ASSERT_IMPL(a_busy_drives, busy_reg, phase_reg != 4'b0000, "no coil driven while busy")
    // A stop beat leaves the controller idle with all coils off.
    `SHSMC_ASSERT_NEXT(a_stop_clears, s1_advance && (s1_cmd_reg == CMD_STOP),
        !busy_reg && (phase_reg == 4'b0000), "stop did not clear the move")

endmodule
